FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL; they expect clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FSNP_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define FSNP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

FILE: rtl/fsnp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fsnp_pkg;

	// ASCII codes
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_C     = 8'h63;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_X     = 8'h78;

	// output character select
	localparam int SEL_W = 3;
	localparam logic [SEL_W-1:0] SEL_CH    = 3'd0;
	localparam logic [SEL_W-1:0] SEL_ARGB  = 3'd1;
	localparam logic [SEL_W-1:0] SEL_PCT   = 3'd2;
	localparam logic [SEL_W-1:0] SEL_MINUS = 3'd3;
	localparam logic [SEL_W-1:0] SEL_ZERO  = 3'd4;
	localparam logic [SEL_W-1:0] SEL_X     = 3'd5;
	localparam logic [SEL_W-1:0] SEL_DIGIT = 3'd6;

	localparam int CNT_W = 5;

	typedef struct packed {
		logic             capture;
		logic             load_hex;
		logic             load_dec;
		logic             negate;
		logic             conv_step;
		logic             dig_shift;
		logic             emit;
		logic [SEL_W-1:0] sel;
		logic             last;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic conv_last;
		logic nib_zero;
		logic cnt_one;
	} sts_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		return (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h57 + {4'd0, nib});
	endfunction

endpackage
`default_nettype wire

FILE: rtl/fsnp_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module fsnp_dpath (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [7:0]      format_char,
	input  wire logic [63:0]     arg_value,
	input  wire fsnp_pkg::cmd_t  cmd,
	output fsnp_pkg::sts_t       sts,
	output logic                 chr_valid,
	input  wire logic            chr_stall,
	output logic [7:0]           out_char,
	output logic                 last_char
);

	logic [7:0]                 ch_q;
	logic [7:0]                 argb_q;
	logic [63:0]                dig_q;
	logic [39:0]                bcd_q;
	logic [39:0]                bcd_adj;
	logic [39:0]                bcd_next;
	logic [31:0]                mag;
	logic [fsnp_pkg::CNT_W-1:0] cnt_q;
	logic                       out_valid_q;
	logic [7:0]                 out_char_q;
	logic                       out_last_q;
	logic [7:0]                 char_mux;

	// add-3 correction of every BCD digit, then shift in next binary bit
	always_comb begin
		for (int i = 0; i < 10; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ?
				bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
		end
		bcd_next = {bcd_adj[38:0], dig_q[63]};
	end

	assign mag = cmd.negate ? (32'd0 - arg_value[31:0]) : arg_value[31:0];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ch_q   <= format_char;
			argb_q <= arg_value[7:0];
		end
		if (cmd.load_hex) begin
			dig_q <= arg_value;
		end else if (cmd.load_dec) begin
			dig_q <= {mag, 32'd0};
			bcd_q <= '0;
		end else if (cmd.conv_step) begin
			bcd_q <= bcd_next;
			if (cnt_q == '0) dig_q <= {bcd_next, 24'd0};
			else             dig_q <= {dig_q[62:0], 1'b0};
		end else if (cmd.dig_shift) begin
			dig_q <= {dig_q[59:0], 4'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load_hex) begin
			cnt_q <= fsnp_pkg::CNT_W'(16);
		end else if (cmd.load_dec) begin
			cnt_q <= fsnp_pkg::CNT_W'(31);
		end else if (cmd.conv_step) begin
			cnt_q <= (cnt_q == '0) ? fsnp_pkg::CNT_W'(10) : cnt_q - 1'b1;
		end else if (cmd.dig_shift) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_comb begin
		unique case (cmd.sel)
			fsnp_pkg::SEL_CH:    char_mux = ch_q;
			fsnp_pkg::SEL_ARGB:  char_mux = argb_q;
			fsnp_pkg::SEL_PCT:   char_mux = fsnp_pkg::CH_PCT;
			fsnp_pkg::SEL_MINUS: char_mux = fsnp_pkg::CH_MINUS;
			fsnp_pkg::SEL_ZERO:  char_mux = fsnp_pkg::CH_ZERO;
			fsnp_pkg::SEL_X:     char_mux = fsnp_pkg::CH_X;
			fsnp_pkg::SEL_DIGIT: char_mux = fsnp_pkg::hex_char(dig_q[63:60]);
			default:             char_mux = ch_q;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!chr_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_char_q <= char_mux;
			out_last_q <= cmd.last;
		end
	end

	assign sts.out_free  = !out_valid_q || !chr_stall;
	assign sts.conv_last = (cnt_q == '0);
	assign sts.nib_zero  = (dig_q[63:60] == 4'd0);
	assign sts.cnt_one   = (cnt_q == fsnp_pkg::CNT_W'(1));

	assign chr_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last_char = out_last_q;

endmodule
`default_nettype wire

FILE: rtl/fsnp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module fsnp_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            fmt_valid,
	output logic                 fmt_stall,
	input  wire logic [7:0]      format_char,
	input  wire logic            arg_sign,
	input  wire fsnp_pkg::sts_t  sts,
	output fsnp_pkg::cmd_t       cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PRE1 = 3'd1;
	localparam logic [2:0] ST_PRE2 = 3'd2;
	localparam logic [2:0] ST_CONV = 3'd3;
	localparam logic [2:0] ST_DIG  = 3'd4;

	logic [2:0]                 state_q, state_d;
	logic                       pending_q;
	logic [fsnp_pkg::SEL_W-1:0] sel1_q, sel2_q;
	logic                       pre2_q, num_q, dec_q, started_q;
	logic                       accept, skip;

	logic                       d_pend, d_pre1, d_pre2, d_num, d_dec, d_neg;
	logic [fsnp_pkg::SEL_W-1:0] d_sel1, d_sel2;

	assign fmt_stall = (state_q != ST_IDLE);
	assign accept    = fmt_valid && !fmt_stall;
	assign skip      = sts.nib_zero && !started_q && !sts.cnt_one;

	// decode of the incoming character
	always_comb begin
		d_pend = 1'b0;
		d_pre1 = 1'b0;
		d_pre2 = 1'b0;
		d_num  = 1'b0;
		d_dec  = 1'b0;
		d_neg  = 1'b0;
		d_sel1 = fsnp_pkg::SEL_CH;
		d_sel2 = fsnp_pkg::SEL_CH;
		if (!pending_q) begin
			if (format_char == fsnp_pkg::CH_PCT) d_pend = 1'b1;
			else                                 d_pre1 = 1'b1;
		end else begin
			unique case (format_char)
				fsnp_pkg::CH_D: begin
					d_num  = 1'b1;
					d_dec  = 1'b1;
					d_neg  = arg_sign;
					d_pre1 = arg_sign;
					d_sel1 = fsnp_pkg::SEL_MINUS;
				end
				fsnp_pkg::CH_U: begin
					d_num = 1'b1;
					d_dec = 1'b1;
				end
				fsnp_pkg::CH_X: begin
					d_num = 1'b1;
				end
				fsnp_pkg::CH_P: begin
					d_num  = 1'b1;
					d_pre1 = 1'b1;
					d_sel1 = fsnp_pkg::SEL_ZERO;
					d_pre2 = 1'b1;
					d_sel2 = fsnp_pkg::SEL_X;
				end
				fsnp_pkg::CH_C: begin
					d_pre1 = 1'b1;
					d_sel1 = fsnp_pkg::SEL_ARGB;
				end
				fsnp_pkg::CH_S: begin
				end
				fsnp_pkg::CH_PCT: begin
					d_pre1 = 1'b1;
					d_sel1 = fsnp_pkg::SEL_PCT;
				end
				default: begin
					d_pre1 = 1'b1;
					d_sel1 = fsnp_pkg::SEL_PCT;
					d_pre2 = 1'b1;
				end
			endcase
		end
	end

	always_comb begin
		cmd         = '0;
		cmd.sel     = fsnp_pkg::SEL_DIGIT;
		cmd.capture = accept;
		cmd.negate  = d_neg;
		state_d     = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load_hex = d_num && !d_dec;
					cmd.load_dec = d_num && d_dec;
					if (d_pre1)     state_d = ST_PRE1;
					else if (d_num) state_d = d_dec ? ST_CONV : ST_DIG;
				end
			end
			ST_PRE1: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = sel1_q;
					cmd.last = !pre2_q && !num_q;
					if (pre2_q)     state_d = ST_PRE2;
					else if (num_q) state_d = dec_q ? ST_CONV : ST_DIG;
					else            state_d = ST_IDLE;
				end
			end
			ST_PRE2: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = sel2_q;
					cmd.last = !num_q;
					if (num_q) state_d = dec_q ? ST_CONV : ST_DIG;
					else       state_d = ST_IDLE;
				end
			end
			ST_CONV: begin
				cmd.conv_step = 1'b1;
				if (sts.conv_last) state_d = ST_DIG;
			end
			ST_DIG: begin
				if (skip) begin
					cmd.dig_shift = 1'b1;
				end else if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.last      = sts.cnt_one;
					cmd.dig_shift = 1'b1;
					if (sts.cnt_one) state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pending_q <= 1'b0;
			sel1_q    <= fsnp_pkg::SEL_CH;
			sel2_q    <= fsnp_pkg::SEL_CH;
			pre2_q    <= 1'b0;
			num_q     <= 1'b0;
			dec_q     <= 1'b0;
			started_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				pending_q <= d_pend;
				sel1_q    <= d_sel1;
				sel2_q    <= d_sel2;
				pre2_q    <= d_pre2;
				num_q     <= d_num;
				dec_q     <= d_dec;
				started_q <= 1'b0;
			end else if (cmd.emit && (state_q == ST_DIG)) begin
				started_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/format_string_number_printer_unit.sv
// A plain character goes through ST_PRE1, a fixed pair through ST_PRE1 and ST_PRE2;
//   %x and %p digits follow at up to one per cycle unless the character channel stalls.
// %d and %u first run the 32-bit magnitude through the shift-and-add-3 BCD converter.
// Leading zeros are skipped. A new request is taken only once the controller is idle.
// Reset (arst_n low, asynchronous): controller idle, no conversion pending, output empty.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module format_string_number_printer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel: one format character and its argument
	input  wire logic        fmt_valid,
	output logic             fmt_stall,
	input  wire logic [7:0]  format_char,
	input  wire logic [63:0] arg_value,
	// character channel
	output logic             chr_valid,
	input  wire logic        chr_stall,
	output logic [7:0]       out_char,
	output logic             last_char
);

	// Controller/datapath split: the controller decodes each request into a
	// sequence of prefix characters and an optional number; the datapath owns
	// the 64-bit digit shifter, the BCD converter and the output register.
	fsnp_pkg::cmd_t cmd;
	fsnp_pkg::sts_t sts;

	fsnp_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.fmt_valid   (fmt_valid),
		.fmt_stall   (fmt_stall),
		.format_char (format_char),
		.arg_sign    (arg_value[31]),
		.sts         (sts),
		.cmd         (cmd)
	);

	// Hex: nibbles leave from the top of the shifter. Decimal: the magnitude is
	// shifted bit by bit into ten BCD digits, which are then parked at the top
	// of the same shifter, so one digit path serves both bases.
	fsnp_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.format_char (format_char),
		.arg_value   (arg_value),
		.cmd         (cmd),
		.sts         (sts),
		.chr_valid   (chr_valid),
		.chr_stall   (chr_stall),
		.out_char    (out_char),
		.last_char   (last_char)
	);

	// a character is only loaded when the output register can take it
	`FSNP_ASSERT_SAME(a_emit_room, cmd.emit, sts.out_free)
	// no new request is taken while the converter runs
	`FSNP_ASSERT_SAME(a_conv_busy, cmd.conv_step, fmt_stall)
	// the final character of a request returns the controller to idle
	`FSNP_ASSERT_NEXT(a_last_idle, cmd.emit && cmd.last, !fmt_stall)

endmodule
`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps
module tb;

	// One format character with its argument, as offered on the request channel.
	typedef struct packed {
		logic [7:0]  fc;
		logic [63:0] arg;
	} format_req_t;

	// One printed character as it should leave the character channel.
	typedef struct packed {
		logic [7:0] glyph;
		logic       last;
	} printed_char_t;

	localparam int unsigned RANDOM_REQS = 450;
	localparam int unsigned HOLD_OFF_AT = 120;  // requests taken before the long hold-off
	localparam int unsigned HOLD_OFF_CYC = 400;
	localparam int unsigned DRAIN_LIMIT = 5000;
	localparam int unsigned TAIL_CYC = 60;      // beyond the slowest decimal path
	localparam logic [8*16-1:0] HEX_GLYPHS = "0123456789abcdef";

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        fmt_valid = 1'b0;
	logic        fmt_stall;
	logic [7:0]  format_char = 8'd0;
	logic [63:0] arg_value = 64'd0;
	logic        chr_valid;
	logic        chr_stall = 1'b0;
	logic [7:0]  out_char;
	logic        last_char;

	format_req_t   pending_reqs_q [$];
	printed_char_t expected_chars_q [$];

	// Predictor state: a '%' has been taken and waits for its selector.
	logic pct_armed = 1'b0;

	// Handshake counters, each written by the monitor only.
	int unsigned reqs_taken = 0;
	int unsigned chars_taken = 0;
	// The driver and the receiver keep their own copies to spot a new handshake.
	int unsigned reqs_seen = 0;
	int unsigned chars_seen = 0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	logic        hold_off = 1'b0;
	int unsigned errors = 0;

	format_string_number_printer_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.fmt_valid  (fmt_valid),
		.fmt_stall  (fmt_stall),
		.format_char(format_char),
		.arg_value  (arg_value),
		.chr_valid  (chr_valid),
		.chr_stall  (chr_stall),
		.out_char   (out_char),
		.last_char  (last_char)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Hard stop, far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic logic [7:0] glyph_of(input logic [3:0] nib);
		return HEX_GLYPHS[8*(15-nib) +: 8];
	endfunction

	function automatic void push_glyph(input logic [7:0] g);
		printed_char_t pc;
		pc.glyph = g;
		pc.last = 1'b0;
		expected_chars_q.push_back(pc);
	endfunction

	// Magnitude in the given base, most significant digit first, zero as "0".
	function automatic void push_number(input logic [63:0] mag, input logic [63:0] base);
		logic [7:0]  digits [$];
		logic [63:0] rest;
		logic [63:0] rem;
		rest = mag;
		do begin
			rem = rest % base;
			digits.push_front(glyph_of(rem[3:0]));
			rest = rest / base;
		end while (rest != 64'd0);
		foreach (digits[i])
			push_glyph(digits[i]);
	endfunction

	// Works out every character one request causes and marks the final one.
	function automatic void predict_printout(input logic [7:0] fc, input logic [63:0] arg);
		int unsigned   before_n;
		logic [31:0]   word;
		printed_char_t tail;
		before_n = expected_chars_q.size();
		if (!pct_armed) begin
			if (fc == fsnp_pkg::CH_PCT)
				pct_armed = 1'b1;
			else
				push_glyph(fc);
		end else begin
			pct_armed = 1'b0;
			case (fc)
				fsnp_pkg::CH_D: begin
					word = arg[31:0];
					if (word[31]) begin
						push_glyph(fsnp_pkg::CH_MINUS);
						word = -word;  // most negative value maps to itself, read unsigned
					end
					push_number({32'd0, word}, 64'd10);
				end
				fsnp_pkg::CH_U: push_number({32'd0, arg[31:0]}, 64'd10);
				fsnp_pkg::CH_X: push_number(arg, 64'd16);
				fsnp_pkg::CH_P: begin
					push_glyph(fsnp_pkg::CH_ZERO);
					push_glyph(fsnp_pkg::CH_X);
					push_number(arg, 64'd16);
				end
				fsnp_pkg::CH_C: push_glyph(arg[7:0]);
				fsnp_pkg::CH_S: ;
				fsnp_pkg::CH_PCT: push_glyph(fsnp_pkg::CH_PCT);
				default: begin
					push_glyph(fsnp_pkg::CH_PCT);
					push_glyph(fc);
				end
			endcase
		end
		if (expected_chars_q.size() > before_n) begin
			tail = expected_chars_q.pop_back();
			tail.last = 1'b1;
			expected_chars_q.push_back(tail);
		end
	endfunction

	// Wait for one request or one character: often none, sometimes short, else longer.
	function automatic int unsigned draw_wait(input logic enable);
		if (!enable)
			return 0;
		case ($urandom_range(0, 3))
			0: return 0;
			1: return $urandom_range(1, 3);
			default: return $urandom_range(0, 16);
		endcase
	endfunction

	// Idling pattern moves on every 64 requests: none, sender, receiver, both.
	function automatic logic [1:0] idle_phase();
		return reqs_taken[7:6];
	endfunction

	function automatic logic [63:0] draw_arg();
		case ($urandom_range(0, 6))
			0: return {56'd0, 8'($urandom_range(0, 20))};
			1: return {32'd0, 32'($urandom)};
			2: return {32'($urandom), 32'($urandom)};
			3: return {32'($urandom), 32'h8000_0000};
			4: return {32'($urandom), 32'hffff_ffff};
			5: return 64'd1 << $urandom_range(0, 63);
			default: return {64{1'b1}} >> $urandom_range(0, 63);
		endcase
	endfunction

	function automatic logic [7:0] draw_plain();
		logic [7:0] ch;
		do ch = 8'($urandom); while (ch == fsnp_pkg::CH_PCT);
		return ch;
	endfunction

	function automatic logic [7:0] draw_selector();
		case ($urandom_range(0, 6))
			0: return fsnp_pkg::CH_D;
			1: return fsnp_pkg::CH_U;
			2: return fsnp_pkg::CH_X;
			3: return fsnp_pkg::CH_P;
			4: return fsnp_pkg::CH_C;
			5: return fsnp_pkg::CH_PCT;
			default: return fsnp_pkg::CH_S;
		endcase
	endfunction

	task automatic queue_req(input logic [7:0] fc, input logic [63:0] arg);
		format_req_t r;
		r.fc = fc;
		r.arg = arg;
		pending_reqs_q.push_back(r);
	endtask

	task automatic queue_conv(input logic [7:0] sel, input logic [63:0] arg);
		queue_req(fsnp_pkg::CH_PCT, 64'($urandom));
		queue_req(sel, arg);
	endtask

	// Driver: moves at the falling edge. A request offered stays put until the
	// monitor has counted it taken; then a fresh gap is drawn for the next one.
	always @(negedge clk) begin : drive_requests
		format_req_t nxt;
		logic [1:0]  phase;
		if (arst_n && (!fmt_valid || reqs_taken != reqs_seen)) begin
			if (fmt_valid) begin
				reqs_seen = reqs_taken;
				phase = idle_phase();
				gap_left = draw_wait(phase[0]);
			end
			if (gap_left > 0) begin
				gap_left--;
				fmt_valid <= 1'b0;
			end else if (pending_reqs_q.size() != 0) begin
				nxt = pending_reqs_q.pop_front();
				fmt_valid <= 1'b1;
				format_char <= nxt.fc;
				arg_value <= nxt.arg;
			end else begin
				fmt_valid <= 1'b0;
			end
		end
	end

	// Receiver: stalls a waiting character for the drawn number of cycles,
	// or throughout the long hold-off.
	always @(negedge clk) begin : drive_char_stall
		logic [1:0] phase;
		if (chars_taken != chars_seen) begin
			chars_seen = chars_taken;
			phase = idle_phase();
			stall_left = draw_wait(phase[1]);
		end
		if (hold_off) begin
			chr_stall <= 1'b1;
		end else if (chr_valid && stall_left > 0) begin
			stall_left--;
			chr_stall <= 1'b1;
		end else begin
			chr_stall <= 1'b0;
		end
	end

	// Monitor: at the rising edge, predicts every request taken and checks
	// every character taken against the oldest one expected.
	always @(posedge clk) begin : watch_channels
		printed_char_t want;
		if (arst_n) begin
			if (fmt_valid && !fmt_stall) begin
				predict_printout(format_char, arg_value);
				reqs_taken <= reqs_taken + 1;
			end
			if (chr_valid && !chr_stall) begin
				chars_taken <= chars_taken + 1;
				if (expected_chars_q.size() == 0) begin
					report_mismatch($sformatf("unexpected character %h last %b",
						out_char, last_char));
				end else begin
					want = expected_chars_q.pop_front();
					if (out_char !== want.glyph)
						report_mismatch($sformatf("out_char expected %h got %h",
							want.glyph, out_char));
					if (last_char !== want.last)
						report_mismatch($sformatf("last_char expected %b got %b (char %h)",
							want.last, last_char, want.glyph));
				end
			end
		end
	end

	// Long hold-off on the character side while requests keep coming, so the
	// block backs up and has to stall its request channel.
	initial begin : long_hold_off
		while (reqs_taken < HOLD_OFF_AT) @(posedge clk);
		hold_off = 1'b1;
		repeat (HOLD_OFF_CYC) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin : run_sequence
		int unsigned n;
		int unsigned i;

		// Directed: echoes at the byte extremes, then each conversion at its edges.
		queue_req(8'h41, 64'd0);
		queue_req(8'h00, {64{1'b1}});                   // NUL echoed
		queue_req(8'hff, 64'd0);
		queue_conv(fsnp_pkg::CH_D, {32'hffff_ffff, 32'h8000_0000}); // most negative
		queue_conv(fsnp_pkg::CH_D, {32'd0, 32'hffff_ffff});
		queue_conv(fsnp_pkg::CH_U, {32'hffff_ffff, 32'hffff_ffff});
		queue_conv(fsnp_pkg::CH_U, 64'd0);               // zero prints as "0"
		queue_conv(fsnp_pkg::CH_X, {64{1'b1}});
		queue_conv(fsnp_pkg::CH_X, 64'd0);
		queue_conv(fsnp_pkg::CH_P, {64{1'b1}});          // longest run of characters
		queue_conv(fsnp_pkg::CH_C, {56'hff_ffff_ffff_ffff, 8'h00}); // zero character
		queue_conv(fsnp_pkg::CH_PCT, 64'd0);
		queue_conv(fsnp_pkg::CH_S, {64{1'b1}});          // nothing printed
		queue_conv(8'h00, 64'd0);                        // NUL after '%'

		// Random: mostly well-formed conversions, with plain text and noise.
		n = 0;
		while (n < RANDOM_REQS) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					queue_req(draw_plain(), draw_arg());
					n += 1;
				end
				3, 4, 5, 6, 7: begin
					queue_conv(draw_selector(), draw_arg());
					n += 2;
				end
				8: begin
					queue_conv(8'($urandom), draw_arg());
					n += 2;
				end
				default: begin
					queue_req(8'($urandom), draw_arg());
					n += 1;
				end
			endcase
		end
		// Trailing '%' left pending: it must print nothing.
		queue_req(fsnp_pkg::CH_PCT, draw_arg());

		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		while (pending_reqs_q.size() != 0 || fmt_valid) @(posedge clk);
		for (i = 0; i < DRAIN_LIMIT && expected_chars_q.size() != 0; i++) @(posedge clk);
		repeat (TAIL_CYC) @(posedge clk);
		if (expected_chars_q.size() != 0)
			report_mismatch($sformatf("%0d characters never printed",
				expected_chars_q.size()));

		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/fsnp_pkg.sv
rtl/fsnp_dpath.sv
rtl/fsnp_ctrl.sv
rtl/format_string_number_printer_unit.sv
test/tb.sv
